// ===== sv/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants of the counting sort engine.
// ----------------------------------------------------------------------------
package cse_pkg;

  // Fixed field widths of the key ports
  localparam int unsigned KEY_FIELD_W = 8;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_KEYS_DEF = 64;
  localparam int unsigned KEY_BITS_DEF = 8;

  // Depth of the queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 4;

  // Per-transaction flags that travel with each queued key
  typedef struct packed {
    logic last;  // closes the set
    logic drop;  // key was discarded, do not count it
    logic ovf;   // set had discarded keys (valid with last)
  } queue_flags_t;

  // Status the back part reports to the front part
  typedef struct packed {
    logic clearing;  // histogram clearing pass after reset is running
  } back_status_t;

  // Back sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_INC      = 6'b000100,
    ST_SCAN_RD  = 6'b001000,
    ST_SCAN_CHK = 6'b010000,
    ST_EMIT     = 6'b100000
  } back_state_e;

endpackage

// ===== sv/cse_front.sv =====
// ----------------------------------------------------------------------------
// cse_front
// Accepts keys, counts them against capacity and classifies each one as
// stored or dropped before it enters the queue.
// ----------------------------------------------------------------------------
module cse_front #(
  parameter int unsigned MAX_KEYS = cse_pkg::MAX_KEYS_DEF,
  parameter int unsigned KEY_BITS = cse_pkg::KEY_BITS_DEF,
  localparam int unsigned CNT_W   = $clog2(MAX_KEYS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cse_pkg::KEY_FIELD_W-1:0] key_value_i,
  input  logic                            set_end_i,
  input  cse_pkg::back_status_t           status_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output logic [KEY_BITS-1:0]             q_key_o,
  output logic [CNT_W-1:0]                q_total_o,
  output cse_pkg::queue_flags_t           q_flags_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic             ovf_q, ovf_d;
  logic             store;
  logic             fire;

  assign in_ready_o = !q_full_i && !status_i.clearing;
  assign fire       = in_valid_i && in_ready_o;

  assign store    = cnt_q < CNT_W'(MAX_KEYS);
  assign cnt_next = store ? cnt_q + CNT_W'(1) : cnt_q;

  assign q_push_o        = fire;
  assign q_key_o         = KEY_BITS'(key_value_i);
  assign q_total_o       = cnt_next;
  assign q_flags_o.last  = set_end_i;
  assign q_flags_o.drop  = !store;
  assign q_flags_o.ovf   = ovf_q || !store;

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (fire) begin
      if (set_end_i) begin
        // start a fresh set
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = cnt_next;
        ovf_d = ovf_q || !store;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

// ===== sv/cse_queue.sv =====
// ----------------------------------------------------------------------------
// cse_queue
// Small FIFO that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module cse_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned DEPTH = cse_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/cse_back.sv =====
// ----------------------------------------------------------------------------
// cse_back
// Histogram memory and sequencer: counts queued keys, then walks the bins
// in ascending order and emits each key as often as it was counted, zeroing
// every bin it has drained.
// ----------------------------------------------------------------------------
module cse_back #(
  parameter int unsigned MAX_KEYS = cse_pkg::MAX_KEYS_DEF,
  parameter int unsigned KEY_BITS = cse_pkg::KEY_BITS_DEF,
  localparam int unsigned CNT_W   = $clog2(MAX_KEYS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_pop_o,
  input  logic [KEY_BITS-1:0]             q_key_i,
  input  logic [CNT_W-1:0]                q_total_i,
  input  cse_pkg::queue_flags_t           q_flags_i,
  output cse_pkg::back_status_t           status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cse_pkg::KEY_FIELD_W-1:0] sorted_key_o,
  output logic                            run_end_o,
  output logic                            keys_dropped_o
);

  localparam int unsigned BIN_COUNT = 2 ** KEY_BITS;

  cse_pkg::back_state_e state_q, state_d;

  // histogram memory
  logic [CNT_W-1:0]    hist_mem [BIN_COUNT];
  logic [CNT_W-1:0]    rdata_q;
  logic [KEY_BITS-1:0] raddr, waddr;
  logic [CNT_W-1:0]    wdata;
  logic                we;

  logic [KEY_BITS-1:0] bin_q, bin_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                last_q, last_d;
  logic                ovf_q, ovf_d;
  logic [CNT_W-1:0]    total_q, total_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    emit_cnt_q, emit_cnt_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [cse_pkg::KEY_FIELD_W-1:0] out_key_q, out_key_d;
  logic                            out_end_q, out_end_d;
  logic                            out_ovf_q, out_ovf_d;

  logic slot_free;
  logic is_final;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_final  = (emit_cnt_q + CNT_W'(1)) == total_q;

  assign status_o.clearing = state_q == cse_pkg::ST_CLEAR;
  assign q_pop_o           = (state_q == cse_pkg::ST_IDLE) && q_valid_i;

  assign out_valid_o    = out_valid_q;
  assign sorted_key_o   = out_key_q;
  assign run_end_o      = out_end_q;
  assign keys_dropped_o = out_ovf_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      hist_mem[waddr] <= wdata;
    end
    rdata_q <= hist_mem[raddr];
  end

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    key_d       = key_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    total_d     = total_q;
    rem_d       = rem_q;
    emit_cnt_d  = emit_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_key_d   = out_key_q;
    out_end_d   = out_end_q;
    out_ovf_d   = out_ovf_q;
    raddr       = bin_q;
    waddr       = bin_q;
    wdata       = '0;
    we          = 1'b0;

    case (state_q)
      cse_pkg::ST_CLEAR: begin
        we    = 1'b1;
        bin_d = bin_q + KEY_BITS'(1);
        if (bin_q == '1) begin
          state_d = cse_pkg::ST_IDLE;
        end
      end

      cse_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          key_d   = q_key_i;
          last_d  = q_flags_i.last;
          ovf_d   = q_flags_i.ovf;
          total_d = q_total_i;
          bin_d   = '0;
          raddr   = q_key_i;
          if (!q_flags_i.drop) begin
            state_d = cse_pkg::ST_INC;
          end else if (q_flags_i.last) begin
            state_d = cse_pkg::ST_SCAN_RD;
          end
        end
      end

      cse_pkg::ST_INC: begin
        we    = 1'b1;
        waddr = key_q;
        wdata = rdata_q + CNT_W'(1);
        if (last_q) begin
          state_d = cse_pkg::ST_SCAN_RD;
        end else begin
          state_d = cse_pkg::ST_IDLE;
        end
      end

      cse_pkg::ST_SCAN_RD: begin
        state_d = cse_pkg::ST_SCAN_CHK;
      end

      cse_pkg::ST_SCAN_CHK: begin
        if (rdata_q == '0) begin
          // skip empty bin, read the next one right away
          bin_d = bin_q + KEY_BITS'(1);
          raddr = bin_q + KEY_BITS'(1);
        end else begin
          rem_d   = rdata_q;
          state_d = cse_pkg::ST_EMIT;
        end
      end

      cse_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_key_d   = cse_pkg::KEY_FIELD_W'(bin_q);
          out_end_d   = is_final;
          out_ovf_d   = ovf_q;
          emit_cnt_d  = emit_cnt_q + CNT_W'(1);
          rem_d       = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            // bin drained: zero it for the next set
            we = 1'b1;
            if (is_final) begin
              emit_cnt_d = '0;
              state_d    = cse_pkg::ST_IDLE;
            end else begin
              bin_d   = bin_q + KEY_BITS'(1);
              state_d = cse_pkg::ST_SCAN_RD;
            end
          end
        end
      end

      default: begin
        state_d = cse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cse_pkg::ST_CLEAR;
      bin_q       <= '0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bin_q       <= bin_d;
      emit_cnt_q  <= emit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    last_q    <= last_d;
    ovf_q     <= ovf_d;
    total_q   <= total_d;
    rem_q     <= rem_d;
    out_key_q <= out_key_d;
    out_end_q <= out_end_d;
    out_ovf_q <= out_ovf_d;
  end

endmodule

// ===== sv/counting_sort_engine.sv =====
// ----------------------------------------------------------------------------
// counting_sort_engine
// Counting sort of one set of keys, closed by the transaction marked last.
// ----------------------------------------------------------------------------
// Keys enter at one per cycle, while the queue has room, into a four-deep
// queue; the back part counts each queued key in the histogram memory by
// one read and one write-back. The transaction marked last starts the sort:
// the back part walks the 2**KEY_BITS bins in ascending order, skipping empty
// bins, and emits the keys of each filled bin at one per cycle while the
// output side is ready, zeroing each bin as it drains and stopping after the
// last key of the set. Keys of the next set queue up meanwhile. After reset
// a clearing pass zeroes all 2**KEY_BITS bins of the histogram, and no key
// is accepted during it. Keys beyond MAX_KEYS in a set are dropped and every
// result of that set carries keys_dropped.
module counting_sort_engine #(
  parameter int unsigned MAX_KEYS = cse_pkg::MAX_KEYS_DEF,
  parameter int unsigned KEY_BITS = cse_pkg::KEY_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cse_pkg::KEY_FIELD_W-1:0] key_value_i,
  input  logic                            set_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cse_pkg::KEY_FIELD_W-1:0] sorted_key_o,
  output logic                            run_end_o,
  output logic                            keys_dropped_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int unsigned FLAG_W = $bits(cse_pkg::queue_flags_t);
  localparam int unsigned ENT_W  = KEY_BITS + CNT_W + FLAG_W;

  cse_pkg::back_status_t status;
  cse_pkg::queue_flags_t push_flags, pop_flags;
  logic [KEY_BITS-1:0]   push_key, pop_key;
  logic [CNT_W-1:0]      push_total, pop_total;
  logic                  q_push, q_full, q_pop, q_valid;
  logic [ENT_W-1:0]      q_wdata, q_rdata;

  cse_front #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_value_i (key_value_i),
    .set_end_i   (set_end_i),
    .status_i    (status),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_key_o     (push_key),
    .q_total_o   (push_total),
    .q_flags_o   (push_flags)
  );

  assign q_wdata = {push_key, push_total, push_flags};

  cse_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign {pop_key, pop_total, pop_flags} = q_rdata;

  cse_back #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_key_i        (pop_key),
    .q_total_i      (pop_total),
    .q_flags_i      (pop_flags),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_key_o   (sorted_key_o),
    .run_end_o      (run_end_o),
    .keys_dropped_o (keys_dropped_o)
  );

endmodule

// ===== verif/counting_sort_checker.sv =====
// ----------------------------------------------------------------------------
// counting_sort_checker
// Watches both channels of the counting sort engine and scores its results.
// ----------------------------------------------------------------------------
// Every accepted key, up to MAX_KEYS per set, is stored and counted in a
// histogram. The transaction that closes a set triggers a counting sort:
// running prefix sums over all bins, then stable placement of the stored keys
// from last to first. The sorted keys are queued as expected results. Each
// accepted result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module counting_sort_checker #(
  parameter int unsigned MAX_KEYS = cse_pkg::MAX_KEYS_DEF,
  parameter int unsigned KEY_BITS = cse_pkg::KEY_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [cse_pkg::KEY_FIELD_W-1:0] key_value_i,
  input  logic                            set_end_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [cse_pkg::KEY_FIELD_W-1:0] sorted_key_i,
  input  logic                            run_end_i,
  input  logic                            keys_dropped_i,
  output int unsigned                     error_count_o,
  output int unsigned                     pending_count_o,
  output int unsigned                     result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BIN_COUNT = 2 ** KEY_BITS;
  localparam int unsigned KEY_MASK  = BIN_COUNT - 1;

  typedef struct packed {
    logic [cse_pkg::KEY_FIELD_W-1:0] key;
    logic                            last;
    logic                            dropped;
  } sorted_entry_t;

  sorted_entry_t                   sorted_q[$];
  logic [cse_pkg::KEY_FIELD_W-1:0] set_keys[$];
  int unsigned                     key_hist[BIN_COUNT];
  logic [cse_pkg::KEY_FIELD_W-1:0] placed[MAX_KEYS];
  logic                            set_overflow;
  int unsigned                     errors;
  int unsigned                     results;
  int unsigned                     bin_key;
  int unsigned                     running_total;
  int unsigned                     set_size;
  sorted_entry_t                   exp_e;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_q.delete();
      set_keys.delete();
      foreach (key_hist[b]) key_hist[b] = 0;
      set_overflow = 1'b0;
      errors       = 0;
      results      = 0;
      error_count_o   <= 0;
      pending_count_o <= 0;
      result_count_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (sorted_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result: key %0d run_end %0b keys_dropped %0b",
                     $realtime, sorted_key_i, run_end_i, keys_dropped_i);
          end
        end else begin
          exp_e = sorted_q.pop_front();
          results++;
          if (sorted_key_i !== exp_e.key || run_end_i !== exp_e.last ||
              keys_dropped_i !== exp_e.dropped) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch on result %0d: expected key %0d run_end %0b %s %0b",
                       $realtime, results, exp_e.key, exp_e.last, "keys_dropped",
                       exp_e.dropped);
              $display("%0t:   actual key %0d run_end %0b keys_dropped %0b",
                       $realtime, sorted_key_i, run_end_i, keys_dropped_i);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        bin_key = int'(key_value_i) & KEY_MASK;
        // drop keys once the store is full, closing key included
        if (set_keys.size() < MAX_KEYS) begin
          set_keys.push_back(bin_key[cse_pkg::KEY_FIELD_W-1:0]);
          key_hist[bin_key]++;
        end else begin
          set_overflow = 1'b1;
        end

        if (set_end_i) begin
          // each bin becomes the end position of its keys
          running_total = 0;
          for (int b = 0; b < BIN_COUNT; b++) begin
            running_total += key_hist[b];
            key_hist[b] = running_total;
          end
          set_size = set_keys.size();
          for (int i = set_size; i > 0; i--) begin
            bin_key = int'(set_keys[i-1]) & KEY_MASK;
            key_hist[bin_key]--;
            placed[key_hist[bin_key]] = bin_key[cse_pkg::KEY_FIELD_W-1:0];
          end
          for (int i = 0; i < set_size; i++) begin
            sorted_q.push_back('{key: placed[i], last: (i + 1 == set_size),
                                 dropped: set_overflow});
          end
          foreach (key_hist[b]) key_hist[b] = 0;
          set_keys.delete();
          set_overflow = 1'b0;
        end
      end

      error_count_o   <= errors;
      pending_count_o <= sorted_q.size();
      result_count_o  <= results;
    end
  end

endmodule

// ===== verif/counting_sort_engine_tb.sv =====
// ----------------------------------------------------------------------------
// counting_sort_engine_tb
// Stimulus and verdict for the counting sort engine.
// ----------------------------------------------------------------------------
// Sends a few hand-picked sets (extreme keys, duplicates, descending order,
// single-key sets), then random sets of mostly small size with full-range or
// narrow key windows, including full and over-capacity sets. The sender
// works in bursts with gaps; the receiver stalls in changing patterns and
// once holds off long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module counting_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_KEYS        = cse_pkg::MAX_KEYS_DEF;
  localparam int unsigned KEY_BITS        = cse_pkg::KEY_BITS_DEF;
  localparam int unsigned RANDOM_KEYS     = 330;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned DRAIN_CYCLES    = 400;

  typedef enum int unsigned {
    RX_STEADY,
    RX_CHOPPY,
    RX_SLUGGISH
  } rx_mode_e;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [cse_pkg::KEY_FIELD_W-1:0] key_value_i;
  logic                            set_end_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [cse_pkg::KEY_FIELD_W-1:0] sorted_key_o;
  logic                            run_end_o;
  logic                            keys_dropped_o;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned result_count;

  logic        hold_off_req;
  int unsigned burst_left;
  int unsigned keys_sent;
  int unsigned sets_sent;
  int unsigned overfull_sets;

  counting_sort_engine #(
    .MAX_KEYS(MAX_KEYS),
    .KEY_BITS(KEY_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_value_i   (key_value_i),
    .set_end_i     (set_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_key_o  (sorted_key_o),
    .run_end_o     (run_end_o),
    .keys_dropped_o(keys_dropped_o)
  );

  counting_sort_checker #(
    .MAX_KEYS(MAX_KEYS),
    .KEY_BITS(KEY_BITS)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .key_value_i    (key_value_i),
    .set_end_i      (set_end_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_key_i   (sorted_key_o),
    .run_end_i      (run_end_o),
    .keys_dropped_i (keys_dropped_o),
    .error_count_o  (error_count),
    .pending_count_o(pending_count),
    .result_count_o (result_count)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("counting_sort_engine test failed");
    $finish;
  end

  // Offer one key; gaps fall between bursts of random length.
  task automatic send_key(input logic [cse_pkg::KEY_FIELD_W-1:0] key, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    key_value_i <= key;
    set_end_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    keys_sent++;
  endtask

  task automatic send_set(input int unsigned set_len, input int unsigned lo,
                          input int unsigned hi);
    for (int unsigned i = 0; i < set_len; i++) begin
      send_key(8'($urandom_range(lo, hi)), i + 1 == set_len);
    end
    sets_sent++;
    if (set_len > MAX_KEYS) overfull_sets++;
  endtask

  // Receiver: changing stall patterns, plus one long hold-off on request.
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    logic        held;
    out_ready_i = 1'b0;
    held        = 1'b0;
    mode        = RX_STEADY;
    mode_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 96);
        end
        mode_left--;
        case (mode)
          RX_STEADY:   out_ready_i <= 1'b1;
          RX_CHOPPY:   out_ready_i <= ($urandom_range(0, 1) == 0);
          default:     out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [cse_pkg::KEY_FIELD_W-1:0] mixed[8];
    int unsigned random_start;
    int unsigned set_len;
    int unsigned lo;
    int unsigned hi;
    mixed         = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd1, 8'd127, 8'd128};
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    key_value_i   = '0;
    set_end_i     = 1'b0;
    hold_off_req  = 1'b0;
    burst_left    = 0;
    keys_sent     = 0;
    sets_sent     = 0;
    overfull_sets = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-key sets at both ends of the range
    send_key(8'd0, 1'b1);
    sets_sent++;
    send_key(8'd255, 1'b1);
    sets_sent++;
    // extremes mixed with duplicates
    foreach (mixed[i]) send_key(mixed[i], i == 7);
    sets_sent++;
    // alternating bit patterns, repeated
    send_key(8'h55, 1'b0);
    send_key(8'hAA, 1'b0);
    send_key(8'h55, 1'b0);
    send_key(8'hAA, 1'b1);
    sets_sent++;
    // strictly descending keys
    for (int i = 7; i >= 0; i--) send_key(8'(i), i == 0);
    sets_sent++;

    // back up the output while a full set and an overfull one arrive
    hold_off_req = 1'b1;
    random_start = keys_sent;
    send_set(MAX_KEYS, 0, 255);
    send_set(MAX_KEYS + 1, 0, 255);

    while (keys_sent - random_start < RANDOM_KEYS) begin
      case ($urandom_range(0, 19))
        0:       set_len = MAX_KEYS;
        1:       set_len = $urandom_range(MAX_KEYS + 1, MAX_KEYS + 8);
        default: set_len = $urandom_range(1, 24);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        lo = 0;
        hi = 255;
      end else begin
        // narrow window for plenty of equal keys
        lo = $urandom_range(0, 255);
        hi = (lo + 7 > 255) ? 255 : lo + 7;
      end
      send_set(set_len, lo, hi);
    end
    in_valid_i <= 1'b0;

    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sorted %0d sets (%0d over capacity) from %0d keys; %0d results checked.",
             sets_sent, overfull_sets, keys_sent, result_count);
    if (error_count == 0) begin
      $display("counting_sort_engine test passed");
    end else begin
      $display("%0d mismatching or unexpected results", error_count);
      $display("counting_sort_engine test failed");
    end
    $finish;
  end

endmodule
